// ----- rtl/u8dec_pkg.sv -----
// Shared types and constants for the UTF-8 byte stream decoder.
package u8dec_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 27;
    localparam int unsigned LEN_W  = 3;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CP_W-1:0]   t_code_point;
    typedef logic [LEN_W-1:0]  t_seq_len;

    // Lead byte classification: mask and match on the top bits
    localparam t_byte LEAD1_MASK  = 8'h80;
    localparam t_byte LEAD1_MATCH = 8'h00;
    localparam t_byte LEAD2_MASK  = 8'hE0;
    localparam t_byte LEAD2_MATCH = 8'hC0;
    localparam t_byte LEAD3_MASK  = 8'hF0;
    localparam t_byte LEAD3_MATCH = 8'hE0;
    localparam t_byte LEAD4_MASK  = 8'hF8;
    localparam t_byte LEAD4_MATCH = 8'hF0;

    // Payload masks per lead type and for continuation bytes
    localparam t_byte PAY2_MASK = 8'h3F;
    localparam t_byte PAY3_MASK = 8'h1F;
    localparam t_byte PAY4_MASK = 8'h0F;
    localparam t_byte PAY5_MASK = 8'h07;
    localparam t_byte CONT_MASK = 8'h3F;

    localparam int unsigned CONT_BITS = 6;

    localparam t_seq_len LEN_1 = 3'd1;
    localparam t_seq_len LEN_2 = 3'd2;
    localparam t_seq_len LEN_3 = 3'd3;
    localparam t_seq_len LEN_4 = 3'd4;
    localparam t_seq_len LEN_5 = 3'd5;

endpackage

// ----- rtl/u8dec_in_if.sv -----
// Input channel: one raw stream byte per word.
interface u8dec_in_if;
    logic                  valid;
    logic                  ready;
    u8dec_pkg::t_byte      in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- rtl/u8dec_out_if.sv -----
// Output channel: one decoded code point and its sequence length per word.
interface u8dec_out_if;
    logic                     valid;
    logic                     ready;
    u8dec_pkg::t_code_point   code_point;
    u8dec_pkg::t_seq_len      seq_length;

    modport source (output valid, output code_point, output seq_length, input ready);
    modport sink   (input valid, input code_point, input seq_length, output ready);
endinterface

// ----- rtl/utf8_byte_stream_decoder_unit.sv -----
// UTF-8 byte stream decoder top level: byte in, code point out.
//
//   channel   dir   word                         handshake
//   i_in      in    in_byte[7:0]                 valid/ready
//   o_out     out   code_point[26:0], seq_length valid/ready
//
// One byte per clock is taken while i_in.ready is high; a result appears in the
// cycle after the byte that completes its sequence. The sequence state and the output register
// are updated at the same edge, so throughput is one byte per cycle when the output is not stalled.
// i_in.ready is low only while a result is held and o_out.ready is low.
// Synchronous reset clears the sequence state and the output valid.
module utf8_byte_stream_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8dec_in_if.sink    i_in,
    u8dec_out_if.source o_out
);
    import u8dec_pkg::*;

    t_code_point r_partial, n_partial;
    t_seq_len    r_remaining, n_remaining;
    t_seq_len    r_size, n_size;

    logic        r_out_valid;
    t_code_point r_out_cp;
    t_seq_len    r_out_len;

    logic        emit;
    t_code_point emit_cp;
    t_seq_len    emit_len;
    t_code_point shifted;
    logic        in_acc;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    assign shifted = {r_partial[CP_W-CONT_BITS-1:0],
                      CONT_BITS'(i_in.in_byte & CONT_MASK)};

    always_comb begin
        n_partial   = r_partial;
        n_remaining = r_remaining;
        n_size      = r_size;
        emit        = 1'b0;
        emit_cp     = shifted;
        emit_len    = r_size;
        if (r_remaining == '0) begin
            if ((i_in.in_byte & LEAD1_MASK) == LEAD1_MATCH) begin
                emit     = 1'b1;
                emit_cp  = CP_W'(i_in.in_byte);
                emit_len = LEN_1;
            end else if ((i_in.in_byte & LEAD2_MASK) == LEAD2_MATCH) begin
                n_partial = CP_W'(i_in.in_byte & PAY2_MASK);
                n_size    = LEN_2;
            end else if ((i_in.in_byte & LEAD3_MASK) == LEAD3_MATCH) begin
                n_partial = CP_W'(i_in.in_byte & PAY3_MASK);
                n_size    = LEN_3;
            end else if ((i_in.in_byte & LEAD4_MASK) == LEAD4_MATCH) begin
                n_partial = CP_W'(i_in.in_byte & PAY4_MASK);
                n_size    = LEN_4;
            end else begin
                // stray continuations and 0xF8..0xFF land here too
                n_partial = CP_W'(i_in.in_byte & PAY5_MASK);
                n_size    = LEN_5;
            end
            if (!emit) begin
                n_remaining = n_size - LEN_1;
            end
        end else begin
            // continuation: prefix bits are not checked
            n_partial   = shifted;
            n_remaining = r_remaining - LEN_1;
            if (n_remaining == '0) begin
                emit      = 1'b1;
                n_partial = '0;
                n_size    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial   <= '0;
            r_remaining <= '0;
            r_size      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_partial   <= n_partial;
                r_remaining <= n_remaining;
                r_size      <= n_size;
            end
            if (in_acc && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && emit) begin
            r_out_cp  <= emit_cp;
            r_out_len <= emit_len;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.code_point = r_out_cp;
    assign o_out.seq_length = r_out_len;

endmodule

// ----- rtl/u8dec_checker.sv -----
// Port-level checks for the UTF-8 decoder, bound to the top level.
module u8dec_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input u8dec_pkg::t_code_point i_code_point,
    input u8dec_pkg::t_seq_len    i_seq_length
);
    import u8dec_pkg::*;

    // a held word stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_code_point)
            && $stable(i_seq_length))
        else $error("output word changed while stalled");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_seq_length >= LEN_1 && i_seq_length <= LEN_5)
        else $error("sequence length out of range");

    // single-byte results are 7-bit values
    a_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_seq_length == LEN_1 |-> i_code_point < CP_W'(128))
        else $error("one-byte result above 0x7F");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a new result only follows an accepted byte
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready))
        else $error("result without an accepted byte");

endmodule

bind utf8_byte_stream_decoder_unit u8dec_checker u_u8dec_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_code_point (o_out.code_point),
    .i_seq_length (o_out.seq_length)
);

// ----- verif/utf8_byte_stream_decoder_unit_test.sv -----
// Self-checking testbench for the UTF-8 byte stream decoder unit.
`timescale 1ns / 100ps

module utf8_byte_stream_decoder_unit_test;
    import u8dec_pkg::*;

    localparam int unsigned CLK_HALF      = 6;
    localparam int unsigned RESET_CYCLES  = 5;
    localparam int unsigned RANDOM_BYTES  = 1500;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned WATCHDOG_MAX  = 2000;

    typedef struct packed {
        t_code_point cp;
        t_seq_len    len;
    } t_decoded_char;

    // Tracks the decoder's sequence state and holds the characters still owed.
    class t_code_point_tracker;
        t_code_point   partial;
        t_seq_len      remaining;
        t_seq_len      seq_size;
        t_decoded_char pending_chars[$];
        int unsigned   errors;

        function new();
            partial   = '0;
            remaining = '0;
            seq_size  = '0;
            errors    = 0;
        endfunction

        function void owe_char(t_code_point cp, t_seq_len len);
            t_decoded_char item;
            item.cp       = cp;
            item.len      = len;
            pending_chars = {pending_chars, item};
        endfunction

        function void take_byte(t_byte b);
            if (remaining == 0) begin
                if ((b & LEAD1_MASK) == LEAD1_MATCH) begin
                    owe_char(t_code_point'(b), LEN_1);
                    return;
                end
                if ((b & LEAD2_MASK) == LEAD2_MATCH) begin
                    partial  = t_code_point'(b & PAY2_MASK);
                    seq_size = LEN_2;
                end else if ((b & LEAD3_MASK) == LEAD3_MATCH) begin
                    partial  = t_code_point'(b & PAY3_MASK);
                    seq_size = LEN_3;
                end else if ((b & LEAD4_MASK) == LEAD4_MATCH) begin
                    partial  = t_code_point'(b & PAY4_MASK);
                    seq_size = LEN_4;
                end else begin
                    // stray continuations and F8..FF all land here
                    partial  = t_code_point'(b & PAY5_MASK);
                    seq_size = LEN_5;
                end
                remaining = seq_size - LEN_1;
            end else begin
                // no prefix check: any byte counts as a continuation here
                partial   = (partial << CONT_BITS) | t_code_point'(b & CONT_MASK);
                remaining = remaining - LEN_1;
                if (remaining == 0) begin
                    owe_char(partial, seq_size);
                    partial  = '0;
                    seq_size = '0;
                end
            end
        endfunction

        function void check_char(t_code_point cp, t_seq_len len);
            t_decoded_char want;
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected word code_point=%h seq_length=%0d", $time, cp, len);
                errors++;
                return;
            end
            want = pending_chars.pop_front();
            if (cp !== want.cp) begin
                $display("%0t: code_point expected %h actual %h", $time, want.cp, cp);
                errors++;
            end
            if (len !== want.len) begin
                $display("%0t: seq_length expected %0d actual %0d", $time, want.len, len);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    u8dec_in_if  byte_ch ();
    u8dec_out_if cp_ch ();

    utf8_byte_stream_decoder_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (cp_ch)
    );

    t_code_point_tracker tracker = new();

    bit          calm;
    int unsigned bytes_sent;
    int unsigned quiet_cycles;
    int unsigned stall_left;

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // mostly zero, often short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(input t_byte b);
        int unsigned gap;
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        tracker.take_byte(b);
        bytes_sent++;
        gap = calm ? 0 : pick_gap();
        if (gap != 0) begin
            byte_ch.valid   <= 1'b0;
            byte_ch.in_byte <= t_byte'($urandom_range(0, 255));
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_char();
        int unsigned len;
        t_byte       lead;
        if ($urandom_range(0, 99) < 15) begin
            send_byte(t_byte'($urandom_range(0, 255)));
            return;
        end
        len = $urandom_range(1, 5);
        case (len)
            1: begin
                lead = {1'b0, 7'($urandom)};
            end
            2: begin
                lead = {3'b110, 5'($urandom)};
            end
            3: begin
                lead = {4'b1110, 4'($urandom)};
            end
            4: begin
                lead = {5'b11110, 3'($urandom)};
            end
            default: begin
                if ($urandom_range(0, 1) == 0) lead = {2'b10, 6'($urandom)};
                else                           lead = {5'b11111, 3'($urandom)};
            end
        endcase
        send_byte(lead);
        repeat (len - 1) send_byte({2'b10, 6'($urandom)});
    endtask

    // result side: check every accepted word, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cp_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (cp_ch.valid && cp_ch.ready) tracker.check_char(cp_ch.code_point, cp_ch.seq_length);
            if (stall_left != 0) begin
                cp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                cp_ch.ready <= 1'b1;
                if (!calm) stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            if ((byte_ch.valid && byte_ch.ready) || (cp_ch.valid && cp_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        calm       = 1'b0;
        bytes_sent = 0;
        i_rst_n         <= 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.in_byte <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: ASCII bounds, each lead class, stray continuation with
        // lead bytes eaten as continuations, and the all-ones 5-byte case
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'hC2); send_byte(8'h80);
        send_byte(8'hDF); send_byte(8'hBF);
        send_byte(8'hE0); send_byte(8'h80); send_byte(8'h80);
        send_byte(8'hF7); send_byte(8'hBF); send_byte(8'hBF); send_byte(8'hBF);
        send_byte(8'hBF); send_byte(8'hC0); send_byte(8'hE0); send_byte(8'hF0);
        send_byte(8'hC0);
        repeat (5) send_byte(8'hFF);

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            calm = (bytes_sent >= RANDOM_BYTES / 2) && (bytes_sent < RANDOM_BYTES * 2 / 3);
            send_random_char();
        end
        calm = 1'b0;
        byte_ch.valid <= 1'b0;

        while (tracker.pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.pending_chars.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
